>>> rtl/ial_pkg.sv
// Shared opcode codes for the integer ALU pipeline.
// No dependencies; imported by the logic path and the top level.
`default_nettype none

package ial_pkg;

    localparam int OP_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 5'd0,
        OP_SUB = 5'd1,
        OP_MUL = 5'd2,
        OP_DIV = 5'd3,
        OP_MOD = 5'd4,
        OP_SHL = 5'd5,
        OP_SHR = 5'd6,
        OP_AND = 5'd7,
        OP_XOR = 5'd8,
        OP_OR  = 5'd9,
        OP_NOT = 5'd10,
        OP_NEG = 5'd11,
        OP_EQ  = 5'd12,
        OP_NE  = 5'd13,
        OP_LT  = 5'd14,
        OP_GE  = 5'd15,
        OP_GT  = 5'd16,
        OP_LE  = 5'd17
    } op_t;

endpackage

`default_nettype wire

>>> rtl/int32_alu_with_overflow.sv
// Integer ALU top level: input stage, multiplier, divider and logic paths.
// The divider sets the pipeline depth; all other paths are aligned to it.
// Throughput is one beat per cycle; a stalled output freezes the whole pipe.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
// Depends on ial_pkg, ial_delay, ial_mul, ial_div and ial_logic.
`default_nettype none

module int32_alu_with_overflow #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operand_a, operand_b, zero fill
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // opcode[4:0], is_signed
    input  logic [ial_pkg::OP_W:0]            s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ALU result, zero fill
    output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    // overflow, divide_by_zero
    output logic [1:0]                        m_axis_tuser
);

    import ial_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int LAT   = W + 2;
    localparam int OUT_W = ((W + 7) / 8) * 8;

    logic                adv;
    logic                vld_reg [LAT+1];
    logic [OP_W-1:0]     op1_reg, op_out;
    logic                sgn1_reg;
    logic [W-1:0]        a1_reg, b1_reg;
    logic [W-1:0]        mul_res, div_res, log_res, mul_res_d, log_res_d;
    logic                mul_ovf, div_dz, log_ovf, mul_ovf_d, log_ovf_d;
    logic [W-1:0]        out_res;
    logic                out_ovf, out_dz;

    // Move the whole pipe unless the output beat is stalled
    assign adv           = !vld_reg[LAT] || m_axis_tready;
    assign s_axis_tready = adv;

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i <= LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg  <= s_axis_tuser[OP_W-1:0];
            sgn1_reg <= s_axis_tuser[OP_W];
            a1_reg   <= s_axis_tdata[W-1:0];
            b1_reg   <= s_axis_tdata[2*W-1:W];
        end
    end

    ial_mul #(.W(W)) u_mul (
        .aclk(aclk), .adv(adv), .a(a1_reg), .b(b1_reg), .sgn(sgn1_reg),
        .res(mul_res), .ovf(mul_ovf)
    );

    ial_div #(.W(W)) u_div (
        .aclk(aclk), .adv(adv), .a(a1_reg), .b(b1_reg), .sgn(sgn1_reg),
        .is_mod(op1_reg == OP_MOD), .res(div_res), .dz(div_dz)
    );

    ial_logic #(.W(W)) u_logic (
        .aclk(aclk), .adv(adv), .op(op1_reg), .sgn(sgn1_reg),
        .a(a1_reg), .b(b1_reg), .res(log_res), .ovf(log_ovf)
    );

    // Align the shorter paths to the divider
    ial_delay #(.WIDTH(W + 1), .DEPTH(W - 2)) u_mul_dly (
        .aclk(aclk), .adv(adv), .din({mul_ovf, mul_res}),
        .dout({mul_ovf_d, mul_res_d})
    );

    ial_delay #(.WIDTH(W + 1), .DEPTH(1)) u_log_dly (
        .aclk(aclk), .adv(adv), .din({log_ovf, log_res}),
        .dout({log_ovf_d, log_res_d})
    );

    ial_delay #(.WIDTH(OP_W), .DEPTH(LAT)) u_op_dly (
        .aclk(aclk), .adv(adv), .din(op1_reg), .dout(op_out)
    );

    // Pick the path that owns this opcode
    always_comb begin
        case (op_out)
            OP_MUL: begin
                out_res = mul_res_d;
                out_ovf = mul_ovf_d;
                out_dz  = 1'b0;
            end
            OP_DIV, OP_MOD: begin
                out_res = div_res;
                out_ovf = 1'b0;
                out_dz  = div_dz;
            end
            default: begin
                out_res = log_res_d;
                out_ovf = log_ovf_d;
                out_dz  = 1'b0;
            end
        endcase
    end

    assign m_axis_tvalid = vld_reg[LAT];
    assign m_axis_tdata  = OUT_W'(out_res);
    assign m_axis_tuser  = {out_dz, out_ovf};

endmodule

`default_nettype wire

>>> rtl/ial_delay.sv
// Enabled shift-register delay line used to align pipeline branches.
// No package dependencies.
`default_nettype none

module ial_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             adv,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Advance all taps together when the pipeline moves
    always_ff @(posedge aclk) begin
        if (adv) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/ial_mul.sv
// Four-stage multiplier with exact overflow detection for signed/unsigned.
// No package dependencies; instantiated by the top level.
`default_nettype none

module ial_mul #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         adv,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sgn,
    output logic [W-1:0] res,
    output logic         ovf
);

    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam int PW = 2 * W;

    logic [W-1:0]     ma_reg, mb_reg;
    logic             neg1_reg, sgn1_reg;
    logic [2*H-1:0]   ll_reg;
    logic [H+L-1:0]   lh_reg, hl_reg;
    logic [2*L-1:0]   hh_reg;
    logic             neg2_reg, sgn2_reg;
    logic [PW-1:0]    p_reg, p_next;
    logic             neg3_reg, sgn3_reg;
    logic [W-1:0]     res_reg, lim;
    logic             ovf_reg;
    logic             na, nb;

    assign na = sgn & a[W-1];
    assign nb = sgn & b[W-1];
    assign lim = !sgn3_reg ? {W{1'b1}} :
                 (neg3_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    assign p_next = PW'(ll_reg) + (PW'(lh_reg) << H) + (PW'(hl_reg) << H)
                  + (PW'(hh_reg) << (2 * H));

    always_ff @(posedge aclk) begin
        if (adv) begin
            // Take magnitudes and product sign
            ma_reg   <= na ? (~a + 1'b1) : a;
            mb_reg   <= nb ? (~b + 1'b1) : b;
            neg1_reg <= na ^ nb;
            sgn1_reg <= sgn;
            // Form half-width partial products
            ll_reg   <= ma_reg[H-1:0] * mb_reg[H-1:0];
            lh_reg   <= ma_reg[H-1:0] * mb_reg[W-1:H];
            hl_reg   <= ma_reg[W-1:H] * mb_reg[H-1:0];
            hh_reg   <= ma_reg[W-1:H] * mb_reg[W-1:H];
            neg2_reg <= neg1_reg;
            sgn2_reg <= sgn1_reg;
            // Sum the full product magnitude
            p_reg    <= p_next;
            neg3_reg <= neg2_reg;
            sgn3_reg <= sgn2_reg;
            // Range check and reapply the sign
            ovf_reg  <= p_reg > PW'(lim);
            res_reg  <= neg3_reg ? (~p_reg[W-1:0] + 1'b1) : p_reg[W-1:0];
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire

>>> rtl/ial_div.sv
// Pipelined restoring divider, one quotient bit per stage, W + 2 stages.
// No package dependencies; instantiated by the top level.
`default_nettype none

module ial_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         adv,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sgn,
    input  logic         is_mod,
    output logic [W-1:0] res,
    output logic         dz
);

    typedef struct packed {
        logic [W-1:0] a;
        logic         dz;
        logic         is_mod;
        logic         neg_q;
        logic         neg_r;
    } side_t;

    side_t        side_reg [W+1];
    logic [W-1:0] rem_reg  [W+1];
    logic [W-1:0] dq_reg   [W+1];
    logic [W-1:0] dv_reg   [W+1];
    logic [W-1:0] res_reg;
    logic         dz_reg;
    logic         na, nb;
    side_t        side_next;

    assign na = sgn & a[W-1];
    assign nb = sgn & b[W-1];

    always_comb begin
        side_next.a      = a;
        side_next.dz     = (b == '0);
        side_next.is_mod = is_mod;
        side_next.neg_q  = na ^ nb;
        side_next.neg_r  = na;
    end

    // Prepare magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            rem_reg[0]  <= '0;
            dq_reg[0]   <= na ? (~a + 1'b1) : a;
            dv_reg[0]   <= nb ? (~b + 1'b1) : b;
        end
    end

    // One restoring step per stage
    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0] t, d;
        logic       ge;
        always_comb begin
            t  = {rem_reg[k-1], dq_reg[k-1][W-1]};
            d  = {1'b0, dv_reg[k-1]};
            ge = (t >= d);
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= ge ? W'(t - d) : t[W-1:0];
                dq_reg[k]   <= {dq_reg[k-1][W-2:0], ge};
                dv_reg[k]   <= dv_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Fix signs and handle a zero divisor
    always_ff @(posedge aclk) begin
        if (adv) begin
            dz_reg <= side_reg[W].dz;
            if (side_reg[W].dz) begin
                res_reg <= side_reg[W].a;
            end else if (side_reg[W].is_mod) begin
                res_reg <= side_reg[W].neg_r ? (~rem_reg[W] + 1'b1) : rem_reg[W];
            end else begin
                res_reg <= side_reg[W].neg_q ? (~dq_reg[W] + 1'b1) : dq_reg[W];
            end
        end
    end

    assign res = res_reg;
    assign dz  = dz_reg;

endmodule

`default_nettype wire

>>> rtl/ial_logic.sv
// Add/sub/shift/logic/compare path: W-stage carrier that reduces the shift
// amount modulo W (weighted fold, then compare and subtract steps), then
// one ALU stage. Depends on ial_pkg for opcodes.
`default_nettype none

module ial_logic #(
    parameter int W = 32
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [ial_pkg::OP_W-1:0]  op,
    input  logic                      sgn,
    input  logic [W-1:0]              a,
    input  logic [W-1:0]              b,
    output logic [W-1:0]              res,
    output logic                      ovf
);

    import ial_pkg::*;

    localparam int SHW = $clog2(W);
    localparam int SW  = $clog2(W * W);

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sgn;
        logic [W-1:0]    a;
        logic [W-1:0]    b;
    } car_t;

    car_t           car_reg [W];
    logic [SW-1:0]  rem_reg [W];
    car_t           car_in;
    logic [W-1:0]   res_reg, res_next;
    logic           ovf_reg, ovf_next;

    // Sum the residues of 2**i modulo W for every set bit; result < W * W
    function automatic logic [SW-1:0] fold_w(logic [W-1:0] v);
        logic [SW-1:0] acc;
        int            wt;
        acc = '0;
        wt  = 1;
        for (int i = 0; i < W; i++) begin
            if (v[i]) begin
                acc = acc + SW'(wt);
            end
            wt = (2 * wt >= W) ? 2 * wt - W : 2 * wt;
        end
        return acc;
    endfunction

    assign car_in = '{op: op, sgn: sgn, a: a, b: b};

    // Fold b in the first stage, then subtract W * 2**m in the next SHW stages
    for (genvar k = 0; k < W; k++) begin : g_red
        localparam int            STEP = (k >= 1 && k <= SHW) ? SHW - k : 0;
        localparam logic [SW-1:0] SUB  = SW'(W << STEP);
        car_t          src;
        logic [SW-1:0] t, tq;
        always_comb begin
            if (k == 0) begin
                src = car_in;
                t   = fold_w(car_in.b);
            end else begin
                src = car_reg[(k == 0) ? 0 : k-1];
                t   = rem_reg[(k == 0) ? 0 : k-1];
            end
            tq = t;
            if (k >= 1 && k <= SHW && t >= SUB) begin
                tq = t - SUB;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                car_reg[k] <= src;
                rem_reg[k] <= tq;
            end
        end
    end

    // Final ALU stage
    always_comb begin
        car_t         c;
        logic [SHW-1:0] sh;
        logic [W:0]   sum, dif;
        logic [W-1:0] af, bf;
        logic         lt, eq;
        c   = car_reg[W-1];
        sh  = rem_reg[W-1][SHW-1:0];
        sum = {1'b0, c.a} + {1'b0, c.b};
        dif = {1'b0, c.a} - {1'b0, c.b};
        af  = {c.a[W-1] ^ c.sgn, c.a[W-2:0]};
        bf  = {c.b[W-1] ^ c.sgn, c.b[W-2:0]};
        lt  = af < bf;
        eq  = c.a == c.b;
        res_next = '0;
        ovf_next = 1'b0;
        case (c.op)
            OP_ADD: begin
                res_next = sum[W-1:0];
                ovf_next = c.sgn ? (~(c.a[W-1] ^ c.b[W-1]) & (c.a[W-1] ^ sum[W-1]))
                                 : sum[W];
            end
            OP_SUB: begin
                res_next = dif[W-1:0];
                ovf_next = c.sgn ? ((c.a[W-1] ^ c.b[W-1]) & (c.a[W-1] ^ dif[W-1]))
                                 : dif[W];
            end
            OP_SHL: res_next = c.a << sh;
            OP_SHR: res_next = (c.a >> sh)
                             | ((c.sgn & c.a[W-1]) ? ~({W{1'b1}} >> sh) : '0);
            OP_AND: res_next = c.a & c.b;
            OP_XOR: res_next = c.a ^ c.b;
            OP_OR:  res_next = c.a | c.b;
            OP_NOT: res_next = ~c.a;
            OP_NEG: res_next = ~c.a + 1'b1;
            OP_EQ:  res_next = W'(eq);
            OP_NE:  res_next = W'(!eq);
            OP_LT:  res_next = W'(lt);
            OP_GE:  res_next = W'(!lt);
            OP_GT:  res_next = W'(!lt && !eq);
            OP_LE:  res_next = W'(lt || eq);
            default: begin
                res_next = '0;
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire
